// File: sv/sarb_pkg.sv
// Package for the set-associative row buffer tag store.
// Holds sizes, command and status codes, and the request/result structs.
package sarb_pkg;
  localparam int WAYS = 4;
  localparam int SETS = 16;
  localparam int BURSTS_PER_BLOCK = 1;
  localparam int COLUMN_BITS = 7;
  localparam int ROW_BITS = 15;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_SHIFT = $clog2(BURSTS_PER_BLOCK);
  localparam int SEG_SHIFT = SET_SHIFT + $clog2(SETS);
  localparam int SEG_BITS = (COLUMN_BITS > SEG_SHIFT) ? COLUMN_BITS - SEG_SHIFT : 0;
  localparam int TAG_BITS = ROW_BITS + SEG_BITS;
  localparam int SEGW = (SEG_BITS > 0) ? SEG_BITS : 1;

  localparam logic [2:0] CMD_FETCH   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_RESTORE = 3'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP_FETCH = 3'd1;
  localparam logic [2:0] ST_RD_MISS   = 3'd2;
  localparam logic [2:0] ST_WR_MISS   = 3'd3;
  localparam logic [2:0] ST_RESTORE   = 3'd4;
  localparam logic [2:0] ST_EVICT_MOD = 3'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [14:0] row;
    logic [6:0]  column;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        fetch_safe;
    logic [14:0] victim_row;
    logic [2:0]  status;
  } res_t;

  // Classified request passed from front to back.
  typedef struct packed {
    logic [2:0]          command;
    logic [SET_BITS-1:0] set;
    logic [TAG_BITS-1:0] tag;
  } op_t;
endpackage

// File: sv/sarb_front.sv
// Front part: accepts requests, derives set and tag, holds one in a queue slot.
// Depends on sarb_pkg.
module sarb_front import sarb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic op_valid,
  output op_t  op,
  input  logic op_take
);
  logic full;
  op_t  slot;
  op_t  op_in;
  logic [COLUMN_BITS-1:0] col;
  logic [SEGW-1:0] seg;

  assign col = request.column[COLUMN_BITS-1:0];
  always_comb begin
    op_in.command = request.command;
    if (SETS > 1) op_in.set = col[SET_SHIFT +: SET_BITS];
    else op_in.set = '0;
    seg = '0;
    if (SEG_BITS > 0) seg = SEGW'(col >> SEG_SHIFT);
    if (SEG_BITS > 0) op_in.tag = TAG_BITS'({request.row[ROW_BITS-1:0], seg});
    else op_in.tag = TAG_BITS'(request.row[ROW_BITS-1:0]);
  end

  assign busy = full;
  assign op_valid = full;
  assign op = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (start && !full) begin
      full <= 1'b1;
    end else if (op_take) begin
      full <= 1'b0;
    end
    if (start && !full) slot <= op_in;
  end
endmodule

// File: sv/sarb_back.sv
// Back part: reads one set from memory, checks, writes the set back if status is OK.
// Depends on sarb_pkg.
module sarb_back import sarb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  op_t  op,
  output logic op_take,
  output logic done,
  output res_t result
);
  localparam int WAY_W = TAG_BITS + 2 + WAY_BITS;
  localparam int LINE = WAYS * WAY_W;
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                valid;
    logic                modified;
    logic [WAY_BITS-1:0] rank;
  } way_t;

  logic [LINE-1:0] mem [SETS];
  logic [SETS-1:0] touched;
  logic [LINE-1:0] rd;
  logic phase;
  way_t cur [WAYS];
  way_t nxt [WAYS];
  logic hit, safe;
  logic [WAY_BITS-1:0] hit_way, lru_way, pway;
  logic [2:0] status;
  logic [14:0] victim;
  logic wr_en;

  function automatic logic [LINE-1:0] pack_line();
    logic [LINE-1:0] v;
    v = '0;
    for (int w = 0; w < WAYS; w++) v[w*WAY_W +: WAY_W] = nxt[w];
    return v;
  endfunction

  always_ff @(posedge clk) begin
    rd <= mem[op.set];
    if (wr_en) mem[op.set] <= pack_line();
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (touched[op.set]) cur[w] = rd[w*WAY_W +: WAY_W];
      else begin
        cur[w] = '0;
        cur[w].rank = WAY_BITS'(w);
      end
    end
    hit = 1'b0; hit_way = '0; lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur[w].valid && cur[w].tag == op.tag) begin
        hit = 1'b1; hit_way = WAY_BITS'(w);
      end
    end
    for (int w = 0; w < WAYS; w++)
      if (cur[w].rank == WAY_BITS'(WAYS - 1)) lru_way = WAY_BITS'(w);
    safe = !(cur[lru_way].valid && cur[lru_way].modified);
    victim = '0;
    if (!safe) victim = 15'(cur[lru_way].tag >> SEG_BITS);
    status = ST_OK;
    pway = hit_way;
    for (int w = 0; w < WAYS; w++) nxt[w] = cur[w];
    unique case (op.command)
      CMD_FETCH: begin
        pway = lru_way;
        if (hit) status = ST_DUP_FETCH;
        else if (!safe) status = ST_EVICT_MOD;
      end
      CMD_READ: if (!hit) status = ST_RD_MISS;
      CMD_WRITE: if (!hit) status = ST_WR_MISS;
      CMD_RESTORE: if (safe) status = ST_RESTORE;
      default: ;
    endcase
    if (op.command == CMD_FETCH || op.command == CMD_READ || op.command == CMD_WRITE) begin
      for (int w = 0; w < WAYS; w++)
        if (cur[w].rank < cur[pway].rank) nxt[w].rank = cur[w].rank + 1'b1;
      nxt[pway].rank = '0;
    end
    if (op.command == CMD_FETCH) begin
      nxt[lru_way].tag = op.tag;
      nxt[lru_way].valid = 1'b1;
      nxt[lru_way].modified = 1'b0;
    end
    if (op.command == CMD_WRITE) nxt[hit_way].modified = 1'b1;
    if (op.command == CMD_RESTORE) nxt[lru_way].modified = 1'b0;
  end

  assign op_take = phase;
  assign wr_en = phase && status == ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      done <= 1'b0;
      touched <= '0;
    end else begin
      done <= phase;
      if (phase) phase <= 1'b0;
      else if (op_valid) phase <= 1'b1;
      if (wr_en) touched[op.set] <= 1'b1;
    end
    result.hit <= hit;
    result.fetch_safe <= safe;
    result.victim_row <= victim;
    result.status <= status;
  end

  a_take: assert property (@(posedge clk) disable iff (rst) op_take |-> op_valid)
    else $error("take without op");
  a_done: assert property (@(posedge clk) disable iff (rst) op_take |=> done)
    else $error("no result after take");
  a_ok_fetch: assert property (@(posedge clk) disable iff (rst)
    (op_take && op.command == CMD_FETCH && status == ST_OK) |-> (!hit && safe))
    else $error("bad fetch");
endmodule

// File: sv/set_assoc_row_buffer_lru_dirty.sv
// Tag store of a set-associative DRAM row-segment buffer, LRU with dirty marks.
// Steps: front slot, then set memory read, then check and write back; done and the
// result are registered from the check. A new request waits until the slot is freed.
// Busy is high while a request is held; the receiver cannot stall.
// Reset clears control; sets read as reset until first written.
module set_assoc_row_buffer_lru_dirty import sarb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);
  logic op_valid, op_take;
  op_t op;

  sarb_front u_front (.clk, .rst, .start, .request, .busy, .op_valid, .op, .op_take);
  sarb_back u_back (.clk, .rst, .op_valid, .op, .op_take, .done, .result);
endmodule

// File: test/testbench.sv
// Testbench for the set-associative row buffer tag store (LRU with modified marks).
// Depends on sarb_pkg and set_assoc_row_buffer_lru_dirty; checks each result against
// a behavioral model of the set recency order, tags and modified marks.
module testbench;
  import sarb_pkg::*;

  localparam logic [2:0] CMD_PROBE = 3'd4;
  localparam int LIMIT = 200000;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  set_assoc_row_buffer_lru_dirty u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  // Model of the tag store.
  logic [TAG_BITS-1:0] tag_mem [SETS][WAYS];
  logic                valid_mem [SETS][WAYS];
  logic                mod_mem [SETS][WAYS];
  int unsigned         rank_mem [SETS][WAYS];

  res_t pending_results [$];
  int errors;
  int cycles = 0;
  int rows_in_use [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void clear_store();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w] = '0;
        valid_mem[s][w] = 1'b0;
        mod_mem[s][w] = 1'b0;
        rank_mem[s][w] = w;
      end
    end
  endfunction

  function automatic void move_to_front(int s, int w);
    int unsigned old;
    old = rank_mem[s][w];
    for (int i = 0; i < WAYS; i++) begin
      if (rank_mem[s][i] < old) rank_mem[s][i]++;
    end
    rank_mem[s][w] = 0;
  endfunction

  function automatic res_t predict_access(req_t r);
    res_t res;
    int s;
    int hit_way;
    int lru;
    logic [TAG_BITS-1:0] tag;
    logic hit;
    logic safe;
    s = int'((r.column >> SET_SHIFT) & (SETS - 1));
    tag = TAG_BITS'((32'(r.row) << SEG_BITS) | (32'(r.column) >> SEG_SHIFT));
    hit = 1'b0;
    hit_way = 0;
    lru = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_mem[s][w] && tag_mem[s][w] == tag && !hit) begin
        hit = 1'b1;
        hit_way = w;
      end
      if (rank_mem[s][w] == WAYS - 1) lru = w;
    end
    safe = !(valid_mem[s][lru] && mod_mem[s][lru]);
    res = '0;
    res.hit = hit;
    res.fetch_safe = safe;
    if (!safe) res.victim_row = 15'(tag_mem[s][lru] >> SEG_BITS);
    res.status = ST_OK;
    case (r.command)
      CMD_FETCH: begin
        if (hit) res.status = ST_DUP_FETCH;
        else if (!safe) res.status = ST_EVICT_MOD;
        else begin
          tag_mem[s][lru] = tag;
          valid_mem[s][lru] = 1'b1;
          mod_mem[s][lru] = 1'b0;
          move_to_front(s, lru);
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (!hit) res.status = (r.command == CMD_READ) ? ST_RD_MISS : ST_WR_MISS;
        else begin
          move_to_front(s, hit_way);
          if (r.command == CMD_WRITE) mod_mem[s][hit_way] = 1'b1;
        end
      end
      CMD_RESTORE: begin
        if (safe) res.status = ST_RESTORE;
        else mod_mem[s][lru] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.hit !== want.hit) report_mismatch("hit", result.hit, want.hit);
        if (result.fetch_safe !== want.fetch_safe)
          report_mismatch("fetch_safe", result.fetch_safe, want.fetch_safe);
        if (result.victim_row !== want.victim_row)
          report_mismatch("victim_row", result.victim_row, want.victim_row);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
      end
    end
  end

  // Sends one request; a directed expectation is compared with the predictor too.
  // Start stays high after the accepting edge; callers lower it before they drain.
  task automatic send_request(input req_t r, input logic check_want, input res_t want);
    res_t got;
    int idle;
    idle = $urandom_range(0, 4);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    got = predict_access(r);
    if (check_want && got !== want) begin
      $display("directed row disagrees with prediction: cmd %0d", r.command);
      errors++;
    end
    pending_results.push_back(got);
  endtask

  function automatic req_t make_req(logic [2:0] c, logic [14:0] rw, logic [6:0] cl);
    req_t r;
    r.command = c;
    r.row = rw;
    r.column = cl;
    return r;
  endfunction

  typedef struct {
    req_t req;
    logic known;
    res_t want;
  } directed_row_t;

  function automatic res_t mk_res(logic h, logic sf, logic [14:0] v, logic [2:0] st);
    res_t r;
    r.hit = h;
    r.fetch_safe = sf;
    r.victim_row = v;
    r.status = st;
    return r;
  endfunction

  directed_row_t directed [$];

  initial begin
    req_t r;
    int pick;
    errors = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    clear_store();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, mostly set 0: misses, other codes, fill, dirty, evict, restore.
    directed = '{
      '{make_req(CMD_READ, 15'h7fff, 7'h7f), 1'b1, mk_res(0, 1, 0, ST_RD_MISS)},
      '{make_req(CMD_WRITE, 15'h0, 7'h0), 1'b1, mk_res(0, 1, 0, ST_WR_MISS)},
      '{make_req(CMD_RESTORE, 15'h0, 7'h0), 1'b1, mk_res(0, 1, 0, ST_RESTORE)},
      '{make_req(CMD_PROBE, 15'h0, 7'h0), 1'b1, mk_res(0, 1, 0, ST_OK)},
      '{make_req(3'd7, 15'h1234, 7'h55), 1'b1, mk_res(0, 1, 0, ST_OK)},
      '{make_req(3'd5, 15'h0, 7'h0), 1'b1, mk_res(0, 1, 0, ST_OK)},
      '{make_req(CMD_FETCH, 15'h0, 7'h0), 1'b1, mk_res(0, 1, 0, ST_OK)},
      '{make_req(CMD_FETCH, 15'h0, 7'h0), 1'b1, mk_res(1, 1, 0, ST_DUP_FETCH)},
      '{make_req(CMD_WRITE, 15'h0, 7'h0), 1'b1, mk_res(1, 1, 0, ST_OK)},
      '{make_req(CMD_FETCH, 15'h7fff, 7'h70), 1'b0, '0},
      '{make_req(CMD_FETCH, 15'h2aaa, 7'h00), 1'b0, '0},
      '{make_req(CMD_FETCH, 15'h5555, 7'h10), 1'b0, '0},
      '{make_req(CMD_FETCH, 15'h0001, 7'h20), 1'b1, mk_res(0, 0, 0, ST_EVICT_MOD)},
      '{make_req(CMD_RESTORE, 15'h0, 7'h30), 1'b1, mk_res(0, 0, 0, ST_OK)},
      '{make_req(CMD_FETCH, 15'h0001, 7'h20), 1'b0, '0},
      '{make_req(CMD_READ, 15'h7fff, 7'h70), 1'b0, '0},
      '{make_req(CMD_WRITE, 15'h7fff, 7'h70), 1'b0, '0},
      '{make_req(CMD_READ, 15'h7fff, 7'h7f), 1'b0, '0},
      '{make_req(CMD_FETCH, 15'h7fff, 7'h7f), 1'b0, '0},
      '{make_req(CMD_WRITE, 15'h7fff, 7'h7f), 1'b0, '0}
    };
    foreach (directed[i]) send_request(directed[i].req, directed[i].known, directed[i].want);

    // Let everything drain before the random part.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    foreach (rows_in_use[i]) rows_in_use[i] = $urandom_range(0, 32767);
    for (int n = 0; n < 950; n++) begin
      // Mostly a small pool of rows on few sets so hits, dirty evictions and
      // restores happen often; the rest is fully random.
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        r.command = 3'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0) r.command = 3'($urandom_range(4, 7));
        r.row = 15'(rows_in_use[$urandom_range(0, 7)]);
        r.column = 7'(($urandom_range(0, 7) << 4) | $urandom_range(0, 1));
      end else begin
        r = req_t'(25'($urandom));
      end
      if (n % 300 == 150) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        foreach (rows_in_use[i]) rows_in_use[i] = $urandom_range(0, 32767);
      end
      send_request(r, 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
